[hdl/b64ld_pkg.sv]
// shared types, codes and the alphabet lookup for the base64 line decoder
`default_nettype none
package b64ld_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned MAX_RES = 3;

  // result kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // special characters and lookup marker
  localparam logic [6:0] BAD_SEXTET = 7'd127;
  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] CR_CHAR    = 8'h0D;
  localparam logic [7:0] LF_CHAR    = 8'h0A;

  // one group of up to three results caused by one character
  typedef struct packed {
    logic [1:0]        num;
    logic [1:0]        kind;
    logic [2:0][7:0]   bytes;
    logic [2:0][15:0]  counts;
  } grp_t;

  // alphabet character to sextet, BAD_SEXTET for anything else
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      v = 8'd62;
    end else if (c == 8'h2F) begin
      v = 8'd63;
    end else begin
      v = {1'b0, BAD_SEXTET};
    end
    return v[6:0];
  endfunction

endpackage
`default_nettype wire

[hdl/b64ld_step.sv]
// line state and per-character decode into a result group
`default_nettype none
module b64ld_step #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          advance,
  input  wire logic [7:0]    char_in,
  output b64ld_pkg::grp_t    grp
);
  import b64ld_pkg::*;

  // phase codes
  localparam logic [2:0] PH_START    = 3'd0;
  localparam logic [2:0] PH_POS1     = 3'd1;
  localparam logic [2:0] PH_POS2     = 3'd2;
  localparam logic [2:0] PH_POS3     = 3'd3;
  localparam logic [2:0] PH_TAIL     = 3'd4;
  localparam logic [2:0] PH_TAIL_CR  = 3'd5;
  localparam logic [2:0] PH_START_CR = 3'd6;

  localparam logic [COUNT_BITS-1:0] CNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

  logic [2:0]            phase_r, phase_nxt;
  logic [5:0]            s0_r, s0_nxt, s1_r, s1_nxt, s2_r, s2_nxt;
  logic                  tp_r, tp_nxt;
  logic                  disc_r, disc_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [COUNT_BITS-1:0] cnt_a, cnt_b, cnt_c;
  logic [6:0]            s;
  logic                  bad, pad, is_lf, is_cr;
  logic                  do_reject, do_finish;

  function automatic logic [15:0] shown(input logic [COUNT_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  // character classes
  assign s     = sextet_of(char_in);
  assign bad   = (s == BAD_SEXTET);
  assign pad   = (char_in == PAD_CHAR);
  assign is_lf = (char_in == LF_CHAR);
  assign is_cr = (char_in == CR_CHAR);

  // saturating counts after one, two and three data bytes
  assign cnt_a = (cnt_r == '1) ? cnt_r : cnt_r + CNT_ONE;
  assign cnt_b = (cnt_a == '1) ? cnt_a : cnt_a + CNT_ONE;
  assign cnt_c = (cnt_b == '1) ? cnt_b : cnt_b + CNT_ONE;

  // decode one character
  always_comb begin
    phase_nxt  = phase_r;
    s0_nxt     = s0_r;
    s1_nxt     = s1_r;
    s2_nxt     = s2_r;
    tp_nxt     = tp_r;
    disc_nxt   = disc_r;
    cnt_nxt    = cnt_r;
    do_reject  = 1'b0;
    do_finish  = 1'b0;
    grp.num    = 2'd0;
    grp.kind   = KIND_DATA;
    grp.bytes  = '0;
    grp.counts = '0;
    grp.bytes[0]  = {s0_r, s1_r[5:4]};
    grp.bytes[1]  = {s1_r[3:0], s2_r[5:2]};
    grp.bytes[2]  = {s2_r[1:0], s[5:0]};
    grp.counts[0] = shown(cnt_a);
    grp.counts[1] = shown(cnt_b);
    grp.counts[2] = shown(cnt_c);
    if (disc_r) begin
      if (is_lf) begin
        disc_nxt  = 1'b0;
        phase_nxt = PH_START;
        tp_nxt    = 1'b0;
        cnt_nxt   = '0;
      end
    end else begin
      case (phase_r)
        PH_POS1: begin
          if (bad) begin
            do_reject = 1'b1;
          end else begin
            s1_nxt    = s[5:0];
            phase_nxt = PH_POS2;
          end
        end
        PH_POS2: begin
          if (pad) begin
            tp_nxt    = 1'b1;
            s2_nxt    = 6'd0;
            phase_nxt = PH_POS3;
          end else if (bad) begin
            do_reject = 1'b1;
          end else begin
            tp_nxt    = 1'b0;
            s2_nxt    = s[5:0];
            phase_nxt = PH_POS3;
          end
        end
        PH_POS3: begin
          if ((!pad && bad) || (tp_r && !pad)) begin
            do_reject = 1'b1;
          end else if (tp_r) begin
            grp.num   = 2'd1;
            cnt_nxt   = cnt_a;
            phase_nxt = PH_TAIL;
          end else if (pad) begin
            grp.num   = 2'd2;
            cnt_nxt   = cnt_b;
            phase_nxt = PH_TAIL;
          end else begin
            grp.num   = 2'd3;
            cnt_nxt   = cnt_c;
            phase_nxt = PH_START;
            tp_nxt    = 1'b0;
          end
        end
        PH_TAIL: begin
          if (is_lf) begin
            do_finish = 1'b1;
          end else if (is_cr) begin
            phase_nxt = PH_TAIL_CR;
          end else begin
            do_reject = 1'b1;
          end
        end
        PH_TAIL_CR, PH_START_CR: begin
          if (is_lf) begin
            do_finish = 1'b1;
          end else begin
            do_reject = 1'b1;
          end
        end
        default: begin
          if (is_lf) begin
            do_finish = 1'b1;
          end else if (is_cr) begin
            phase_nxt = PH_START_CR;
          end else if (bad) begin
            do_reject = 1'b1;
          end else begin
            s0_nxt    = s[5:0];
            tp_nxt    = 1'b0;
            phase_nxt = PH_POS1;
          end
        end
      endcase
      // line end or rejection starts a new line
      if (do_reject || do_finish) begin
        grp.num   = 2'd1;
        grp.kind  = do_reject ? KIND_REJECT : KIND_END;
        grp.bytes = '0;
        grp.counts[0] = do_reject ? 16'd0 : shown(cnt_r);
        phase_nxt = PH_START;
        tp_nxt    = 1'b0;
        cnt_nxt   = '0;
        disc_nxt  = do_reject && !is_lf;
      end
    end
  end

  // line state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      tp_r    <= 1'b0;
      disc_r  <= 1'b0;
      cnt_r   <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      tp_r    <= tp_nxt;
      disc_r  <= disc_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // sextet store, no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      s0_r <= s0_nxt;
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/b64ld_resbuf.sv]
// result group register that hands out one result per transfer
`default_nettype none
module b64ld_resbuf (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           load,
  input  wire b64ld_pkg::grp_t grp,
  output logic                free,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [1:0]          out_result_kind,
  output logic [7:0]          out_data_byte,
  output logic [15:0]         out_byte_count,
  output logic                out_last_of_run
);
  import b64ld_pkg::*;

  grp_t       grp_r;
  logic       vld_r, vld_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       last, xfer;

  // output view of the current slot
  assign last            = (idx_r == grp_r.num - 2'd1);
  assign xfer            = vld_r && out_ready;
  assign free            = !vld_r || (xfer && last);
  assign out_valid       = vld_r;
  assign out_result_kind = grp_r.kind;
  assign out_data_byte   = grp_r.bytes[idx_r];
  assign out_byte_count  = grp_r.counts[idx_r];
  assign out_last_of_run = last;

  // slot sequencing
  always_comb begin
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    if (xfer) begin
      if (last) begin
        vld_nxt = 1'b0;
        idx_nxt = 2'd0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
    if (load && grp.num != 2'd0) begin
      vld_nxt = 1'b1;
      idx_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  // group payload, no reset
  always_ff @(posedge clk) begin
    if (load && grp.num != 2'd0) begin
      grp_r <= grp;
    end
  end

endmodule
`default_nettype wire

[hdl/base64_line_decoder.sv]
// base64 line decoder: one character per transfer in, decoded bytes and line status out
// a character's first result is loaded into the result register after the character
//   has passed the input register, once the result register is free to take its group
// throughput: 1 character per cycle while the result register is free; a character
//   that completes a group holds it for 1 to 3 results, one result per output transfer
// reset: synchronous active low, clears line phase, byte count, discard flag and valids
// the sextet store is not reset; every entry is written within a group before use
`default_nettype none
module base64_line_decoder #(
  parameter int unsigned COUNT_BITS = b64ld_pkg::COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_result_kind,
  output logic [7:0]       out_data_byte,
  output logic [15:0]      out_byte_count,
  output logic             out_last_of_run
);
  import b64ld_pkg::*;

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_char_r;
  logic       free, advance;
  grp_t       grp;

  // input register moves on when the result register can take its group
  assign advance  = in_vld_r && free;
  assign in_ready = !in_vld_r || advance;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (advance) begin
      in_vld_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char_r <= in_char_in;
    end
  end

  // decode and line state
  b64ld_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .char_in (in_char_r),
    .grp     (grp)
  );

  // result group serializer
  b64ld_resbuf u_resbuf (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (advance),
    .grp             (grp),
    .free            (free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_data_byte   (out_data_byte),
    .out_byte_count  (out_byte_count),
    .out_last_of_run (out_last_of_run)
  );

endmodule
`default_nettype wire

[tb/tb_top.sv]
// self-checking testbench for the base64 line decoder: directed and random lines against a predictor
module tb_top;
  import b64ld_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RANDOM_ITEMS = 440;
  localparam int NUM_ROWS     = 30;
  localparam int MAX_REPORTS  = 40;

  // one result as seen on the output channel
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] count;
    logic        last;
  } b64_result_t;

  // position within the line, mirrors the decoder's phase
  typedef enum logic [2:0] {
    GROUP_0, GROUP_1, GROUP_2, GROUP_3, TAIL, TAIL_CR, START_CR
  } line_phase_t;

  // how a directed row is checked
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_check_t;

  typedef struct {
    logic [7:0]  ch;
    row_check_t  chk;
    logic [1:0]  kind;
    logic [15:0] cnt;
  } stim_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char_in = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_result_kind;
  logic [7:0]  out_data_byte;
  logic [15:0] out_byte_count;
  logic        out_last_of_run;

  // predictor state
  line_phase_t line_phase;
  logic [5:0]  sextets [3];
  logic        pad_in_third;
  logic [15:0] line_bytes;
  logic        skipping_line;

  b64_result_t char_results [$];
  b64_result_t awaited [$];

  bit          idling_on = 1'b1;
  int unsigned stall_left;
  int unsigned stall_draw;
  int unsigned error_count;
  int unsigned sent_chars;
  int unsigned checked_results;
  int unsigned end_results;
  int unsigned reject_results;

  // directed rows: line ends, padding, several kinds of rejection, field extremes
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{LF_CHAR,  CHK_ONE,   KIND_END,    16'd0},
    '{"/",      CHK_MODEL, KIND_DATA,   16'd0},
    '{"/",      CHK_MODEL, KIND_DATA,   16'd0},
    '{"/",      CHK_MODEL, KIND_DATA,   16'd0},
    '{"/",      CHK_MODEL, KIND_DATA,   16'd0},
    '{CR_CHAR,  CHK_NONE,  KIND_DATA,   16'd0},
    '{LF_CHAR,  CHK_ONE,   KIND_END,    16'd3},
    '{PAD_CHAR, CHK_ONE,   KIND_REJECT, 16'd0},
    '{8'h00,    CHK_NONE,  KIND_DATA,   16'd0},
    '{LF_CHAR,  CHK_NONE,  KIND_DATA,   16'd0},
    '{"A",      CHK_NONE,  KIND_DATA,   16'd0},
    '{PAD_CHAR, CHK_ONE,   KIND_REJECT, 16'd0},
    '{8'hFF,    CHK_NONE,  KIND_DATA,   16'd0},
    '{LF_CHAR,  CHK_NONE,  KIND_DATA,   16'd0},
    '{"Q",      CHK_NONE,  KIND_DATA,   16'd0},
    '{"Q",      CHK_NONE,  KIND_DATA,   16'd0},
    '{PAD_CHAR, CHK_NONE,  KIND_DATA,   16'd0},
    '{"A",      CHK_ONE,   KIND_REJECT, 16'd0},
    '{LF_CHAR,  CHK_NONE,  KIND_DATA,   16'd0},
    '{CR_CHAR,  CHK_NONE,  KIND_DATA,   16'd0},
    '{CR_CHAR,  CHK_ONE,   KIND_REJECT, 16'd0},
    '{LF_CHAR,  CHK_NONE,  KIND_DATA,   16'd0},
    '{"z",      CHK_NONE,  KIND_DATA,   16'd0},
    '{LF_CHAR,  CHK_ONE,   KIND_REJECT, 16'd0},
    '{"Q",      CHK_MODEL, KIND_DATA,   16'd0},
    '{"Q",      CHK_MODEL, KIND_DATA,   16'd0},
    '{PAD_CHAR, CHK_MODEL, KIND_DATA,   16'd0},
    '{PAD_CHAR, CHK_MODEL, KIND_DATA,   16'd0},
    '{"9",      CHK_ONE,   KIND_REJECT, 16'd0},
    '{LF_CHAR,  CHK_NONE,  KIND_DATA,   16'd0}
  };

  base64_line_decoder i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_in      (in_char_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_data_byte   (out_data_byte),
    .out_byte_count  (out_byte_count),
    .out_last_of_run (out_last_of_run)
  );

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // run limit
  initial begin
    #(CLK_PERIOD * 1_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // alphabet character to its six-bit value, 127 when outside the alphabet
  function automatic logic [6:0] alphabet_index(input logic [7:0] ch);
    if (ch inside {[8'h41:8'h5A]}) return 7'(ch - 8'h41);
    if (ch inside {[8'h61:8'h7A]}) return 7'(ch - 8'h47);
    if (ch inside {[8'h30:8'h39]}) return 7'(ch + 8'h04);
    if (ch == 8'h2B) return 7'd62;
    if (ch == 8'h2F) return 7'd63;
    return BAD_SEXTET;
  endfunction

  // six-bit value back to its alphabet character
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    if (v < 6'd26) return 8'h41 + 8'(v);
    if (v < 6'd52) return 8'h47 + 8'(v);
    if (v < 6'd62) return 8'(v) - 8'h04;
    return (v == 6'd62) ? 8'h2B : 8'h2F;
  endfunction

  function automatic void start_line();
    line_phase   = GROUP_0;
    pad_in_third = 1'b0;
    line_bytes   = 16'd0;
  endfunction

  function automatic void push_result(input logic [1:0] kind, input logic [7:0] data,
                                      input logic [15:0] count);
    char_results.push_back(b64_result_t'{kind, data, count, 1'b0});
  endfunction

  // decoded byte, count saturates at the top of its range
  function automatic void emit_byte(input logic [7:0] data);
    if (line_bytes != 16'hFFFF) line_bytes = line_bytes + 16'd1;
    push_result(KIND_DATA, data, line_bytes);
  endfunction

  function automatic void reject_line(input logic [7:0] ch);
    push_result(KIND_REJECT, 8'h00, 16'd0);
    start_line();
    skipping_line = (ch != LF_CHAR);
  endfunction

  function automatic void finish_line();
    push_result(KIND_END, 8'h00, line_bytes);
    start_line();
  endfunction

  // predictor: one accepted character, results land in char_results
  function automatic void decode_char(input logic [7:0] ch);
    logic [6:0] s;
    logic       bad;
    logic       pad4;
    s    = alphabet_index(ch);
    bad  = (s == BAD_SEXTET);
    pad4 = (ch == PAD_CHAR);
    char_results.delete();
    // rest of a rejected line is dropped up to LF
    if (skipping_line) begin
      if (ch == LF_CHAR) begin
        skipping_line = 1'b0;
        start_line();
      end
      return;
    end
    case (line_phase)
      GROUP_1: begin
        if (bad) begin
          reject_line(ch);
        end else begin
          sextets[1] = s[5:0];
          line_phase = GROUP_2;
        end
      end
      GROUP_2: begin
        if (pad4) begin
          pad_in_third = 1'b1;
          sextets[2]   = 6'd0;
          line_phase   = GROUP_3;
        end else if (bad) begin
          reject_line(ch);
        end else begin
          pad_in_third = 1'b0;
          sextets[2]   = s[5:0];
          line_phase   = GROUP_3;
        end
      end
      GROUP_3: begin
        if ((!pad4 && bad) || (pad_in_third && !pad4)) begin
          reject_line(ch);
        end else begin
          emit_byte({sextets[0], sextets[1][5:4]});
          if (pad_in_third) begin
            line_phase = TAIL;
          end else begin
            emit_byte({sextets[1][3:0], sextets[2][5:2]});
            if (pad4) begin
              line_phase = TAIL;
            end else begin
              emit_byte({sextets[2][1:0], s[5:0]});
              line_phase   = GROUP_0;
              pad_in_third = 1'b0;
            end
          end
        end
      end
      TAIL: begin
        if (ch == LF_CHAR) finish_line();
        else if (ch == CR_CHAR) line_phase = TAIL_CR;
        else reject_line(ch);
      end
      TAIL_CR, START_CR: begin
        if (ch == LF_CHAR) finish_line();
        else reject_line(ch);
      end
      default: begin
        if (ch == LF_CHAR) begin
          finish_line();
        end else if (ch == CR_CHAR) begin
          line_phase = START_CR;
        end else if (bad) begin
          reject_line(ch);
        end else begin
          sextets[0]   = s[5:0];
          pad_in_third = 1'b0;
          line_phase   = GROUP_1;
        end
      end
    endcase
    if (char_results.size() != 0) char_results[char_results.size() - 1].last = 1'b1;
  endfunction

  // one character transfer, then queue what it should produce
  task automatic send_char(input logic [7:0] ch, input row_check_t chk = CHK_MODEL,
                           input logic [1:0] kind = KIND_DATA, input logic [15:0] cnt = 16'd0);
    int unsigned gap;
    gap = idling_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_char_in <= ch;
    do @(posedge clk); while (!in_ready);
    sent_chars++;
    decode_char(ch);
    case (chk)
      CHK_MODEL: foreach (char_results[i]) awaited.push_back(char_results[i]);
      CHK_ONE: awaited.push_back(b64_result_t'{kind, 8'h00, cnt, 1'b1});
      default: ;
    endcase
  endtask

  // hold the input off until every queued result is out
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited.size() != 0);
  endtask

  // mostly well-formed lines, some with one bad character, some pure noise
  task automatic send_random_line();
    logic [7:0]  line_buf [$];
    int unsigned groups;
    int unsigned form;
    int unsigned pads;
    int unsigned pos;
    int unsigned k;
    groups = $urandom_range(0, 5);
    form   = $urandom_range(0, 9);
    if (form == 9) begin
      k = $urandom_range(1, 8);
      repeat (k) line_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      for (k = 0; k < groups * 4; k++) line_buf.push_back(sextet_char(6'($urandom_range(0, 63))));
      if (groups != 0) begin
        pads = $urandom_range(0, 2);
        if (pads >= 1) line_buf[line_buf.size() - 1] = PAD_CHAR;
        if (pads == 2) line_buf[line_buf.size() - 2] = PAD_CHAR;
      end
    end
    if ($urandom_range(0, 1) != 0) line_buf.push_back(CR_CHAR);
    line_buf.push_back(LF_CHAR);
    // corrupt one position
    if (form == 7 || form == 8) begin
      pos = $urandom_range(0, line_buf.size() - 1);
      case ($urandom_range(0, 3))
        0: line_buf[pos] = PAD_CHAR;
        1: line_buf[pos] = CR_CHAR;
        2: line_buf[pos] = LF_CHAR;
        default: line_buf[pos] = 8'($urandom_range(0, 255));
      endcase
    end
    foreach (line_buf[i]) send_char(line_buf[i]);
  endtask

  // ready side: random stall after each result transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      stall_draw = idling_on ? $urandom_range(0, 5) : 0;
      if (stall_draw != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_draw;
      end
    end else if (!out_ready) begin
      if (stall_left <= 1) out_ready <= 1'b1;
      if (stall_left != 0) stall_left <= stall_left - 1;
    end
  end

  function automatic void report_mismatch(input string field, input logic [15:0] want,
                                          input logic [15:0] got);
    error_count++;
    if (error_count <= MAX_REPORTS) $error("%s: expected %0h, got %0h", field, want, got);
  endfunction

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    b64_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $error("result kind %0d with nothing expected", out_result_kind);
      end else begin
        want = awaited.pop_front();
        checked_results++;
        if (want.kind == KIND_END) end_results++;
        if (want.kind == KIND_REJECT) reject_results++;
        if (out_result_kind !== want.kind)
          report_mismatch("result_kind", 16'(want.kind), 16'(out_result_kind));
        if (out_data_byte !== want.data)
          report_mismatch("data_byte", 16'(want.data), 16'(out_data_byte));
        if (out_byte_count !== want.count)
          report_mismatch("byte_count", want.count, out_byte_count);
        if (out_last_of_run !== want.last)
          report_mismatch("last_of_run", 16'(want.last), 16'(out_last_of_run));
      end
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    int unsigned r;
    int unsigned start_items;
    skipping_line = 1'b0;
    start_line();
    do @(posedge clk); while (!rst_n);

    for (r = 0; r < NUM_ROWS; r++)
      send_char(directed_rows[r].ch, directed_rows[r].chk, directed_rows[r].kind,
                directed_rows[r].cnt);

    // random lines, some of them with no idling at all
    start_items = sent_chars;
    while (sent_chars - start_items < RANDOM_ITEMS) begin
      idling_on = ($urandom_range(0, 3) != 0);
      send_random_line();
      if ($urandom_range(0, 11) == 0) wait_for_results();
    end
    idling_on = 1'b1;

    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d characters sent, %0d results checked (%0d line ends, %0d rejections),",
             sent_chars, checked_results, end_results, reject_results);
    $display("covering padded groups, every rejection path and stalls on both sides");
    if (error_count == 0 && awaited.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
